@@ rtl/lztd_pkg.sv @@
// Shared types and constants of the LZ token decompressor.
package lztd_pkg;

  localparam int unsigned OUT_LANES_DEF = 8;
  localparam int unsigned CNT_W         = 4;
  localparam int unsigned HIST_DEPTH    = 128;
  localparam int unsigned HIST_AW       = 7;
  localparam int unsigned PROD_W        = 8;
  localparam int unsigned REM_W         = 9;
  localparam int unsigned MIN_MATCH     = 3;

  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_LEN  = 2'd1,
    PH_LIT  = 2'd2,
    PH_FAIL = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNC_REF = 2'd1,
    ST_BAD_OFF   = 2'd2,
    ST_TRUNC_LIT = 2'd3
  } status_e;

  typedef enum logic {
    ENG_IDLE = 1'b0,
    ENG_COPY = 1'b1
  } eng_state_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [3:0]  byte_count;
    logic        run_last;
    logic        stream_done;
    status_e     status;
  } out_item_t;

  // Byte push and item close from the control into the packer.
  typedef struct packed {
    logic       push;
    logic [7:0] data;
    logic       close;
    logic       eos;
    status_e    status;
  } pk_req_t;

  // Packer state as seen by the control.
  typedef struct packed {
    logic             closing;
    logic             flush;
    logic [CNT_W-1:0] cnt_after;
  } pk_stat_t;

endpackage

@@ rtl/lztd_history.sv @@
// 128-byte history ring: one write and one registered read per cycle, with write forwarding.
module lztd_history
  import lztd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [HIST_AW-1:0] waddr_i,
  input  logic [7:0]         wdata_i,
  input  logic               re_i,
  input  logic [HIST_AW-1:0] raddr_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem_q [HIST_DEPTH];
  logic [7:0] rd_q;
  logic [7:0] fwd_q;
  logic       hit_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q  <= mem_q[raddr_i];
      fwd_q <= wdata_i;
    end
  end

  // A read that hits the entry written in the same cycle takes the new byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (re_i) begin
      hit_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = hit_q ? fwd_q : rd_q;

endmodule

@@ rtl/lztd_packer.sv @@
// Byte accumulator and output register that packs produced bytes into result beats.
module lztd_packer
  import lztd_pkg::*;
#(
  parameter int unsigned OUT_LANES = OUT_LANES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pk_req_t   req_i,
  output pk_stat_t  stat_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic [7:0]       acc_q [OUT_LANES];
  logic [7:0]       acc_d [OUT_LANES];
  logic [CNT_W-1:0] cnt_q, cnt_d, base_cnt;
  logic             closing_q, closing_d;
  logic             eos_q;
  status_e          status_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic             out_free, full, flush, emit;
  logic [63:0]      word;

  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (cnt_q == CNT_W'(OUT_LANES));

  always_comb begin
    word = '0;
    for (int i = 0; i < OUT_LANES; i++) begin
      if (CNT_W'(i) < cnt_q) begin
        word[8*i +: 8] = acc_q[i];
      end
    end
  end

  always_comb begin
    emit  = 1'b0;
    flush = 1'b0;
    if (closing_q) begin
      emit  = (cnt_q != '0) || eos_q;
      // drop an empty close that carries no stream end
      flush = emit ? out_free : 1'b1;
    end else if (full) begin
      emit  = 1'b1;
      flush = out_free;
    end
    emit = emit && flush;

    base_cnt  = flush ? '0 : cnt_q;
    cnt_d     = base_cnt + CNT_W'(req_i.push);
    closing_d = req_i.close || (closing_q && !flush);
    for (int i = 0; i < OUT_LANES; i++) begin
      acc_d[i] = acc_q[i];
      if (req_i.push && (base_cnt == CNT_W'(i))) begin
        acc_d[i] = req_i.data;
      end
    end

    out_d            = out_q;
    out_d.out_word   = word;
    out_d.byte_count = cnt_q;
    out_d.run_last   = closing_q;
    out_d.stream_done = closing_q && eos_q;
    out_d.status     = (closing_q && eos_q) ? status_q : ST_OK;

    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      closing_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      closing_q   <= closing_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (req_i.close) begin
      eos_q    <= req_i.eos;
      status_q <= req_i.status;
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign stat_o.closing   = closing_q;
  assign stat_o.flush     = flush;
  assign stat_o.cnt_after = base_cnt;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(OUT_LANES))
    else $error("accumulator holds more bytes than lanes");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || !out_stall_i))
    else $error("result beat overwritten while stalled");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.push |-> (base_cnt < CNT_W'(OUT_LANES)))
    else $error("byte pushed into a full accumulator");
`endif

endmodule

@@ rtl/lz_token_decompressor.sv @@
// Top level of the LZ token decompressor: token parser, copy engine and stream status.
// A literal byte reaches a result beat via the accumulator and the output register.
// Throughput: literal and tag beats are taken one per cycle while the output drains
// and no copy runs. A back-reference copies its length byte plus MIN_MATCH bytes,
// one per cycle through the history read port, holding a read until its byte fits.
// Reset clears parser, engine and packer control; the history ring is not cleared.
module lz_token_decompressor
  import lztd_pkg::*;
#(
  parameter int unsigned OUT_LANES = OUT_LANES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  // Parser state
  phase_e             phase_q, phase_d;
  logic [6:0]         lit_rem_q, lit_rem_d;
  logic [6:0]         off_q, off_d;
  logic [HIST_AW-1:0] wp_q, wp_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  status_e            err_q, err_d;

  // Copy engine state
  eng_state_e         eng_q, eng_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [HIST_AW-1:0] src_q, src_d;
  logic               eos_pend_q, eos_pend_d;
  logic               inflight_q, last_q;

  logic               accept, ready, rd_en, lit_we, hist_we;
  logic [7:0]         hist_rdata;
  logic [CNT_W:0]     slots_used;
  pk_req_t            req;
  pk_stat_t           pk_stat;

  // Take a new beat only with the engine idle and any close flushing out.
  assign ready      = (eng_q == ENG_IDLE) && (!pk_stat.closing || pk_stat.flush);
  assign in_stall_o = !ready;
  assign accept     = in_valid_i && ready;

  // Issue a history read only when its byte is sure to fit in the accumulator.
  assign slots_used = {1'b0, pk_stat.cnt_after} + {{CNT_W{1'b0}}, inflight_q};
  assign rd_en      = (eng_q == ENG_COPY) && (rem_q != '0)
                      && (slots_used < (CNT_W+1)'(OUT_LANES));

  assign hist_we = lit_we || inflight_q;

  always_comb begin
    phase_d    = phase_q;
    lit_rem_d  = lit_rem_q;
    off_d      = off_q;
    wp_d       = wp_q;
    prod_d     = prod_q;
    err_d      = err_q;
    eng_d      = eng_q;
    rem_d      = rem_q;
    src_d      = src_q;
    eos_pend_d = eos_pend_q;
    lit_we     = 1'b0;
    req        = '0;

    // Copied byte returns: write it back at the head, advance and pack it.
    if (inflight_q) begin
      wp_d     = wp_q + 1'b1;
      prod_d   = (prod_q < PROD_W'(HIST_DEPTH)) ? prod_q + 1'b1 : prod_q;
      req.push = 1'b1;
      req.data = hist_rdata;
      if (last_q) begin
        eng_d      = ENG_IDLE;
        req.close  = 1'b1;
        req.eos    = eos_pend_q;
        req.status = err_q;
        if (eos_pend_q) begin
          phase_d   = PH_TAG;
          lit_rem_d = '0;
          off_d     = '0;
          wp_d      = '0;
          prod_d    = '0;
          err_d     = ST_OK;
        end
      end
    end

    if (rd_en) begin
      src_d = src_q + 1'b1;
      rem_d = rem_q - 1'b1;
    end

    if (accept) begin
      unique case (phase_q)
        PH_TAG: begin
          if (in_data_i.in_byte[7]) begin
            off_d   = in_data_i.in_byte[6:0];
            phase_d = PH_LEN;
            if (in_data_i.end_of_stream) begin
              err_d   = ST_TRUNC_REF;
              phase_d = PH_FAIL;
            end
          end else if (in_data_i.in_byte != '0) begin
            lit_rem_d = in_data_i.in_byte[6:0];
            phase_d   = PH_LIT;
            if (in_data_i.end_of_stream) begin
              err_d   = ST_TRUNC_LIT;
              phase_d = PH_FAIL;
            end
          end
          req.close = 1'b1;
        end
        PH_LEN: begin
          phase_d = PH_TAG;
          if ((off_q == '0) || ({1'b0, off_q} > prod_q)) begin
            err_d     = ST_BAD_OFF;
            phase_d   = PH_FAIL;
            req.close = 1'b1;
          end else begin
            eng_d      = ENG_COPY;
            rem_d      = {1'b0, in_data_i.in_byte} + REM_W'(MIN_MATCH);
            src_d      = wp_q - off_q;
            eos_pend_d = in_data_i.end_of_stream;
          end
        end
        PH_LIT: begin
          lit_we    = 1'b1;
          wp_d      = wp_q + 1'b1;
          prod_d    = (prod_q < PROD_W'(HIST_DEPTH)) ? prod_q + 1'b1 : prod_q;
          req.push  = 1'b1;
          req.data  = in_data_i.in_byte;
          lit_rem_d = lit_rem_q - 1'b1;
          if (lit_rem_d == '0) begin
            phase_d = PH_TAG;
          end else if (in_data_i.end_of_stream) begin
            err_d   = ST_TRUNC_LIT;
            phase_d = PH_FAIL;
          end
          req.close = 1'b1;
        end
        PH_FAIL: begin
          // drop the beat, only the stream end reports
          req.close = 1'b1;
        end
        default: begin
          req.close = 1'b1;
        end
      endcase
      req.eos    = in_data_i.end_of_stream;
      req.status = err_d;
      // Stream end closes here unless a copy still has to run.
      if (in_data_i.end_of_stream && (eng_d == ENG_IDLE)) begin
        phase_d   = PH_TAG;
        lit_rem_d = '0;
        off_d     = '0;
        wp_d      = '0;
        prod_d    = '0;
        err_d     = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_TAG;
      lit_rem_q  <= '0;
      off_q      <= '0;
      wp_q       <= '0;
      prod_q     <= '0;
      err_q      <= ST_OK;
      eng_q      <= ENG_IDLE;
      rem_q      <= '0;
      src_q      <= '0;
      eos_pend_q <= 1'b0;
      inflight_q <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      lit_rem_q  <= lit_rem_d;
      off_q      <= off_d;
      wp_q       <= wp_d;
      prod_q     <= prod_d;
      err_q      <= err_d;
      eng_q      <= eng_d;
      rem_q      <= rem_d;
      src_q      <= src_d;
      eos_pend_q <= eos_pend_d;
      inflight_q <= rd_en;
      last_q     <= rd_en && (rem_q == REM_W'(1));
    end
  end

  lztd_history u_history (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (hist_we),
    .waddr_i (wp_q),
    .wdata_i (inflight_q ? hist_rdata : in_data_i.in_byte),
    .re_i    (rd_en),
    .raddr_i (src_q),
    .rdata_o (hist_rdata)
  );

  lztd_packer #(
    .OUT_LANES (OUT_LANES)
  ) u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .stat_o      (pk_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_inflight_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q |-> (eng_q == ENG_COPY))
    else $error("history read returned outside a copy");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lit_we && inflight_q))
    else $error("literal and copy write the history in one cycle");

  a_prod_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_q <= PROD_W'(HIST_DEPTH))
    else $error("produced count above history depth");

  a_copy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q && last_q) |=> (eng_q == ENG_IDLE) && !inflight_q)
    else $error("copy engine busy after its last byte");
`endif

endmodule
